### hdl/d2q9_pkg.sv
// d2q9_pkg: shared constants, types and fixed-point helpers for the D2Q9 BGK collision block.
// Depends on nothing; used by d2q9_moments, d2q9_lane and the top level.
package d2q9_pkg;

    localparam int WORD_BITS     = 24;
    localparam int FRACTION_BITS = 20;
    localparam int RATE_BITS     = 22;
    localparam int DIRS          = 9;
    localparam int SUM_BITS      = WORD_BITS + 4;
    localparam int PROD_BITS     = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic [RATE_BITS-1:0]        rate_t;

    // Direction classes, used to pick the weight and the projection e.u
    typedef enum logic [3:0] {
        DIR_REST, DIR_E, DIR_N, DIR_W, DIR_S, DIR_NE, DIR_NW, DIR_SW, DIR_SE
    } dir_t;

    localparam word_t W_REST = word_t'(((4 * (2 ** FRACTION_BITS)) + 4) / 9);
    localparam word_t W_AXIS = word_t'(((2 ** FRACTION_BITS) + 4) / 9);
    localparam word_t W_DIAG = word_t'(((2 ** FRACTION_BITS) + 18) / 36);
    localparam word_t C_3    = word_t'(3 * (2 ** FRACTION_BITS));
    localparam word_t C_1P5  = word_t'(3 * (2 ** (FRACTION_BITS - 1)));
    localparam word_t C_4P5  = word_t'(9 * (2 ** (FRACTION_BITS - 1)));

    localparam word_t WORD_MAX = word_t'((2 ** (WORD_BITS - 1)) - 1);
    localparam word_t WORD_MIN = word_t'(-(2 ** (WORD_BITS - 1)));

    // Saturate a wide sum to the word range
    function automatic word_t sat_sum(input sum_t x);
        if (x > sum_t'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (x < sum_t'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return x[WORD_BITS-1:0];
    endfunction

    // Floor-shift a full product by the fraction bits and saturate
    function automatic word_t sat_prod(input prod_t p);
        prod_t s;
        s = p >>> FRACTION_BITS;
        if (s > prod_t'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (s < prod_t'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic prod_t mul(input word_t a, input word_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

endpackage

### hdl/d2q9_moments.sv
// d2q9_moments: merges the nine distributions into density and momenta (saturated).
// Depends on d2q9_pkg. Pure logic; registered by the caller.
module d2q9_moments (
    input  d2q9_pkg::word_t f [d2q9_pkg::DIRS],
    output d2q9_pkg::word_t rho,
    output d2q9_pkg::word_t ux,
    output d2q9_pkg::word_t uy
);
    d2q9_pkg::sum_t s, sx, sy;

    always_comb begin
        s = '0;
        for (int k = 0; k < d2q9_pkg::DIRS; k++) begin
            s = s + d2q9_pkg::sum_t'(f[k]);
        end
        sx = d2q9_pkg::sum_t'(f[1]) - d2q9_pkg::sum_t'(f[3]) + d2q9_pkg::sum_t'(f[5])
           - d2q9_pkg::sum_t'(f[6]) - d2q9_pkg::sum_t'(f[7]) + d2q9_pkg::sum_t'(f[8]);
        sy = d2q9_pkg::sum_t'(f[2]) - d2q9_pkg::sum_t'(f[4]) + d2q9_pkg::sum_t'(f[5])
           + d2q9_pkg::sum_t'(f[6]) - d2q9_pkg::sum_t'(f[7]) - d2q9_pkg::sum_t'(f[8]);
    end

    assign rho = d2q9_pkg::sat_sum(s);
    assign ux  = d2q9_pkg::sat_sum(sx);
    assign uy  = d2q9_pkg::sat_sum(sy);

endmodule

### hdl/d2q9_lane.sv
// d2q9_lane: one direction's equilibrium and relaxation, four pipeline stages, stall by enable.
// Depends on d2q9_pkg. Instantiated nine times by the top level.
module d2q9_lane (
    input  logic             aclk,
    input  logic             en,
    input  d2q9_pkg::dir_t   dir,
    input  d2q9_pkg::word_t  f_in,
    input  d2q9_pkg::word_t  rho_in,
    input  d2q9_pkg::word_t  ux_in,
    input  d2q9_pkg::word_t  uy_in,
    input  d2q9_pkg::word_t  uu_in,
    input  d2q9_pkg::rate_t  omega,
    output d2q9_pkg::word_t  post
);
    d2q9_pkg::sum_t  eu_sum;
    d2q9_pkg::word_t eu, wk;

    // stage A: eu and its products
    d2q9_pkg::word_t f_a_reg, rho_a_reg, eu3_a_reg, uu15_a_reg, eu2_a_reg;
    // stage B: bracket
    d2q9_pkg::word_t f_b_reg, br_b_reg;
    // stage C: feq and difference
    d2q9_pkg::word_t f_c_reg, d_c_reg;
    // stage D: relaxed output
    d2q9_pkg::word_t post_reg;

    d2q9_pkg::word_t eu2q;
    d2q9_pkg::sum_t  br_sum, d_sum, post_sum;
    d2q9_pkg::prod_t od;

    always_comb begin
        unique case (dir)
            d2q9_pkg::DIR_REST: eu_sum = '0;
            d2q9_pkg::DIR_E:    eu_sum = d2q9_pkg::sum_t'(ux_in);
            d2q9_pkg::DIR_N:    eu_sum = d2q9_pkg::sum_t'(uy_in);
            d2q9_pkg::DIR_W:    eu_sum = -d2q9_pkg::sum_t'(ux_in);
            d2q9_pkg::DIR_S:    eu_sum = -d2q9_pkg::sum_t'(uy_in);
            d2q9_pkg::DIR_NE:   eu_sum = d2q9_pkg::sum_t'(ux_in) + d2q9_pkg::sum_t'(uy_in);
            d2q9_pkg::DIR_NW:   eu_sum = d2q9_pkg::sum_t'(uy_in) - d2q9_pkg::sum_t'(ux_in);
            d2q9_pkg::DIR_SW:   eu_sum = -d2q9_pkg::sum_t'(ux_in) - d2q9_pkg::sum_t'(uy_in);
            d2q9_pkg::DIR_SE:   eu_sum = d2q9_pkg::sum_t'(ux_in) - d2q9_pkg::sum_t'(uy_in);
            default:            eu_sum = '0;
        endcase
        unique case (dir) inside
            d2q9_pkg::DIR_REST:                    wk = d2q9_pkg::W_REST;
            d2q9_pkg::DIR_E, d2q9_pkg::DIR_N,
            d2q9_pkg::DIR_W, d2q9_pkg::DIR_S:      wk = d2q9_pkg::W_AXIS;
            default:                               wk = d2q9_pkg::W_DIAG;
        endcase
    end

    assign eu   = d2q9_pkg::sat_sum(eu_sum);
    assign eu2q = d2q9_pkg::sat_prod(d2q9_pkg::mul(eu, eu));

    // eu^2 is registered before the 4.5 multiply
    d2q9_pkg::word_t eu2_45;
    assign eu2_45 = d2q9_pkg::sat_prod(d2q9_pkg::mul(eu2_a_reg, d2q9_pkg::C_4P5));
    assign br_sum = d2q9_pkg::sum_t'(rho_a_reg) + d2q9_pkg::sum_t'(eu3_a_reg)
                  - d2q9_pkg::sum_t'(uu15_a_reg) + d2q9_pkg::sum_t'(eu2_45);

    d2q9_pkg::word_t wk_b_reg, feq;
    assign feq   = d2q9_pkg::sat_prod(d2q9_pkg::mul(wk_b_reg, br_b_reg));
    assign d_sum = d2q9_pkg::sum_t'(feq) - d2q9_pkg::sum_t'(f_b_reg);

    // omega is at most 22 bits unsigned, fits the signed product
    assign od = d2q9_pkg::prod_t'({1'b0, omega}) * d2q9_pkg::prod_t'(d_c_reg);
    assign post_sum = d2q9_pkg::sum_t'(f_c_reg) + d2q9_pkg::sum_t'(d2q9_pkg::sat_prod(od));

    d2q9_pkg::word_t wk_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f_a_reg    <= f_in;
            rho_a_reg  <= rho_in;
            wk_a_reg   <= wk;
            eu3_a_reg  <= d2q9_pkg::sat_prod(d2q9_pkg::mul(eu, d2q9_pkg::C_3));
            uu15_a_reg <= d2q9_pkg::sat_prod(d2q9_pkg::mul(uu_in, d2q9_pkg::C_1P5));
            eu2_a_reg  <= eu2q;
            f_b_reg    <= f_a_reg;
            wk_b_reg   <= wk_a_reg;
            br_b_reg   <= d2q9_pkg::sat_sum(br_sum);
            f_c_reg    <= f_b_reg;
            d_c_reg    <= d2q9_pkg::sat_sum(d_sum);
            post_reg   <= d2q9_pkg::sat_sum(post_sum);
        end
    end

    assign post = post_reg;

endmodule

### hdl/d2q9_bgk_cell_collision.sv
// d2q9_bgk_cell_collision: top level, D2Q9 BGK collision of one cell per request.
// Seven register stages lie between an accepted request and its result.
// Throughput: one request per clock while enabled; all stages advance together with a global enable.
// The enable drops only when the output holds a result that is not taken.
// Reset (aresetn, synchronous, active low) empties the pipeline and sets omega to 0.9.
// Depends on d2q9_pkg, d2q9_moments, d2q9_lane.
module d2q9_bgk_cell_collision (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [21:0]            cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [23:0]     s_dist_rest,
    input  logic signed [23:0]     s_dist_east,
    input  logic signed [23:0]     s_dist_north,
    input  logic signed [23:0]     s_dist_west,
    input  logic signed [23:0]     s_dist_south,
    input  logic signed [23:0]     s_dist_northeast,
    input  logic signed [23:0]     s_dist_northwest,
    input  logic signed [23:0]     s_dist_southwest,
    input  logic signed [23:0]     s_dist_southeast,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [23:0]     m_post_rest,
    output logic signed [23:0]     m_post_east,
    output logic signed [23:0]     m_post_north,
    output logic signed [23:0]     m_post_west,
    output logic signed [23:0]     m_post_south,
    output logic signed [23:0]     m_post_northeast,
    output logic signed [23:0]     m_post_northwest,
    output logic signed [23:0]     m_post_southwest,
    output logic signed [23:0]     m_post_southeast,
    output logic signed [23:0]     m_density,
    output logic signed [23:0]     m_x_momentum,
    output logic signed [23:0]     m_y_momentum
);
    // input, moments, squares, then the four lane stages
    localparam int STAGES = 7;

    d2q9_pkg::rate_t omega_reg;
    d2q9_pkg::word_t f_in [d2q9_pkg::DIRS];
    d2q9_pkg::word_t rho_c, ux_c, uy_c;

    // stage 0: registered input request
    d2q9_pkg::word_t f0_reg [d2q9_pkg::DIRS];
    // stage 1: saturated moments
    d2q9_pkg::word_t f1_reg [d2q9_pkg::DIRS];
    d2q9_pkg::word_t rho1_reg, ux1_reg, uy1_reg;
    // stage 2: squared momenta (registered after the multiply)
    d2q9_pkg::word_t f2_reg [d2q9_pkg::DIRS];
    d2q9_pkg::word_t rho2_reg, ux2_reg, uy2_reg, uxx2_reg, uyy2_reg;
    // moment outputs follow the lanes through their four stages
    d2q9_pkg::word_t mom_reg [4][3];

    d2q9_pkg::word_t post [d2q9_pkg::DIRS];
    d2q9_pkg::word_t uu2;

    logic [STAGES-1:0] vld_reg;
    logic              en;

    // pipeline moves unless the last stage holds an untaken result
    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[STAGES-1];

    assign f_in[0] = s_dist_rest;
    assign f_in[1] = s_dist_east;
    assign f_in[2] = s_dist_north;
    assign f_in[3] = s_dist_west;
    assign f_in[4] = s_dist_south;
    assign f_in[5] = s_dist_northeast;
    assign f_in[6] = s_dist_northwest;
    assign f_in[7] = s_dist_southwest;
    assign f_in[8] = s_dist_southeast;

    d2q9_moments u_moments (
        .f   (f0_reg),
        .rho (rho_c),
        .ux  (ux_c),
        .uy  (uy_c)
    );

    assign uu2 = d2q9_pkg::sat_sum(d2q9_pkg::sum_t'(uxx2_reg) + d2q9_pkg::sum_t'(uyy2_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            omega_reg <= d2q9_pkg::rate_t'(((9 * (2 ** d2q9_pkg::FRACTION_BITS)) + 5) / 10);
        end else begin
            if (cfg_we) begin
                omega_reg <= cfg_wdata;
            end
            if (en) begin
                vld_reg <= {vld_reg[STAGES-2:0], s_valid};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f0_reg   <= f_in;
            f1_reg   <= f0_reg;
            rho1_reg <= rho_c;
            ux1_reg  <= ux_c;
            uy1_reg  <= uy_c;
            f2_reg   <= f1_reg;
            rho2_reg <= rho1_reg;
            ux2_reg  <= ux1_reg;
            uy2_reg  <= uy1_reg;
            uxx2_reg <= d2q9_pkg::sat_prod(d2q9_pkg::mul(ux1_reg, ux1_reg));
            uyy2_reg <= d2q9_pkg::sat_prod(d2q9_pkg::mul(uy1_reg, uy1_reg));
            mom_reg[0][0] <= rho2_reg;
            mom_reg[0][1] <= ux2_reg;
            mom_reg[0][2] <= uy2_reg;
            for (int i = 1; i < 4; i++) begin
                mom_reg[i] <= mom_reg[i-1];
            end
        end
    end

    // nine lanes in parallel, one per lattice direction
    for (genvar k = 0; k < d2q9_pkg::DIRS; k++) begin : g_lane
        d2q9_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .dir    (d2q9_pkg::dir_t'(k)),
            .f_in   (f2_reg[k]),
            .rho_in (rho2_reg),
            .ux_in  (ux2_reg),
            .uy_in  (uy2_reg),
            .uu_in  (uu2),
            .omega  (omega_reg),
            .post   (post[k])
        );
    end

    assign m_post_rest      = post[0];
    assign m_post_east      = post[1];
    assign m_post_north     = post[2];
    assign m_post_west      = post[3];
    assign m_post_south     = post[4];
    assign m_post_northeast = post[5];
    assign m_post_northwest = post[6];
    assign m_post_southwest = post[7];
    assign m_post_southeast = post[8];
    // lanes are four deep; mom_reg[3] lines up with the lane outputs
    assign m_density        = mom_reg[3][0];
    assign m_x_momentum     = mom_reg[3][1];
    assign m_y_momentum     = mom_reg[3][2];

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_density) && $stable(m_post_rest))
        else $error("result changed while stalled");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted request not tracked");
`endif

endmodule

### test/d2q9_bgk_cell_collision_test.sv
// Testbench for d2q9_bgk_cell_collision: random and directed cells, checked against a predictor.
// Depends on d2q9_pkg and the d2q9_bgk_cell_collision RTL.
`timescale 1ns / 1ps

module d2q9_bgk_cell_collision_test;

    localparam longint SAT_HI = (64'sd1 <<< 23) - 1;
    localparam longint SAT_LO = -(64'sd1 <<< 23);
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [23:0] f0, f1, f2, f3, f4, f5, f6, f7, f8;
    } cell_t;

    typedef struct {
        longint v [12];
    } moments_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [21:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic signed [23:0] s_dist [9];
    logic m_valid;
    logic m_ready;
    logic signed [23:0] m_field [12];

    cell_t cell_queue [$];
    moments_t expected_queue [$];
    logic [21:0] omega;
    int failures;
    int cycles;
    int hold_cycles;
    bit quiet_mode;
    bit hold_request;
    logic s_ready_seen;

    string names [12] = '{"post_rest", "post_east", "post_north", "post_west",
        "post_south", "post_northeast", "post_northwest", "post_southwest",
        "post_southeast", "density", "x_momentum", "y_momentum"};
    logic [21:0] rates [5] = '{22'd0, 22'd2097152, 22'h3fffff, 22'd524288, 22'd1500000};

    d2q9_bgk_cell_collision i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_dist_rest(s_dist[0]), .s_dist_east(s_dist[1]), .s_dist_north(s_dist[2]),
        .s_dist_west(s_dist[3]), .s_dist_south(s_dist[4]),
        .s_dist_northeast(s_dist[5]), .s_dist_northwest(s_dist[6]),
        .s_dist_southwest(s_dist[7]), .s_dist_southeast(s_dist[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_post_rest(m_field[0]), .m_post_east(m_field[1]), .m_post_north(m_field[2]),
        .m_post_west(m_field[3]), .m_post_south(m_field[4]),
        .m_post_northeast(m_field[5]), .m_post_northwest(m_field[6]),
        .m_post_southwest(m_field[7]), .m_post_southeast(m_field[8]),
        .m_density(m_field[9]), .m_x_momentum(m_field[10]), .m_y_momentum(m_field[11])
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint clamp(input longint x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    // floor(a*b / 2^20), clamped; 24x24 products fit easily in 64 bits
    function automatic longint fx_mul(input longint a, input longint b);
        return clamp((a * b) >>> d2q9_pkg::FRACTION_BITS);
    endfunction

    function automatic moments_t collide(input cell_t c, input logic [21:0] w);
        int ex [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        int ey [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        longint f [9];
        longint sum, sx, sy, rho, ux, uy, uu, wk, eu, eu2, br, feq, d;
        moments_t r;
        f = '{c.f0, c.f1, c.f2, c.f3, c.f4, c.f5, c.f6, c.f7, c.f8};
        sum = 0;
        sx = 0;
        sy = 0;
        for (int k = 0; k < 9; k++) begin
            sum += f[k];
            sx += ex[k] * f[k];
            sy += ey[k] * f[k];
        end
        rho = clamp(sum);
        ux = clamp(sx);
        uy = clamp(sy);
        uu = clamp(fx_mul(ux, ux) + fx_mul(uy, uy));
        for (int k = 0; k < 9; k++) begin
            wk = (k == 0) ? longint'(d2q9_pkg::W_REST)
               : (k < 5 ? longint'(d2q9_pkg::W_AXIS) : longint'(d2q9_pkg::W_DIAG));
            eu = clamp(ex[k] * ux + ey[k] * uy);
            eu2 = fx_mul(eu, eu);
            br = clamp(rho + fx_mul(eu, d2q9_pkg::C_3) - fx_mul(uu, d2q9_pkg::C_1P5)
                       + fx_mul(eu2, d2q9_pkg::C_4P5));
            feq = fx_mul(wk, br);
            d = clamp(feq - f[k]);
            r.v[k] = clamp(f[k] + fx_mul(longint'(w), d));
        end
        r.v[9] = rho;
        r.v[10] = ux;
        r.v[11] = uy;
        return r;
    endfunction

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($signed($urandom_range(0, 2097152)) - 1048576);
            3: return 24'($signed($urandom_range(0, 262144)) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    // Driver: new request offered at the falling edge, held until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready_seen) begin
            s_valid <= 1'b1;
        end else if (cell_queue.size() > 0 && !hold_request
                     && (quiet_mode || $urandom_range(0, 99) >= 12)) begin
            cell_t c;
            c = cell_queue.pop_front();
            s_valid <= 1'b1;
            s_dist[0] <= c.f0; s_dist[1] <= c.f1; s_dist[2] <= c.f2;
            s_dist[3] <= c.f3; s_dist[4] <= c.f4; s_dist[5] <= c.f5;
            s_dist[6] <= c.f6; s_dist[7] <= c.f7; s_dist[8] <= c.f8;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver backpressure, with a long hold-off when requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_mode || ($urandom_range(0, 99) >= 12);
        end
    end

    // Acceptance flag for the driver, sampled at the rising edge
    always @(posedge aclk) begin
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_queue.push_back(collide({s_dist[0], s_dist[1], s_dist[2], s_dist[3],
                s_dist[4], s_dist[5], s_dist[6], s_dist[7], s_dist[8]}, omega));
        end
    end

    // Monitor: compare every result with the oldest expectation
    always @(posedge aclk) begin
        moments_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_queue.size() == 0) begin
                $error("unexpected result");
                failures++;
            end else begin
                e = expected_queue.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (longint'(m_field[k]) != e.v[k]) begin
                        $error("%s expected %0d got %0d", names[k], e.v[k], m_field[k]);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_cell(input cell_t c);
        cell_queue.push_back(c);
    endtask

    // wait until nothing is pending, offered or in flight
    task automatic drain();
        @(posedge aclk);
        while (cell_queue.size() != 0 || s_valid || expected_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_omega(input logic [21:0] w);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_we <= 1'b0;
        omega = w;
    endtask

    task automatic random_cells(input int n);
        cell_t c;
        for (int i = 0; i < n; i++) begin
            c = {pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                 pick_value(), pick_value(), pick_value(), pick_value()};
            add_cell(c);
        end
    endtask

    initial begin
        cell_t c;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        for (int k = 0; k < 9; k++) s_dist[k] = '0;
        failures = 0;
        cycles = 0;
        hold_cycles = 0;
        quiet_mode = 1'b0;
        hold_request = 1'b0;
        omega = 22'd943718;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zeros, all max, all min, alternating signs, pure x and y flows
        add_cell('0);
        add_cell({9{24'sh7fffff}});
        add_cell({9{24'sh800000}});
        add_cell({24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
                  24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff});
        add_cell({24'sh100000, 24'sh7fffff, 24'sh0, 24'sh800000, 24'sh0,
                  24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff});
        add_cell({24'sh100000, 24'sh0, 24'sh7fffff, 24'sh0, 24'sh800000,
                  24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000});
        // most negative momentum on both axes
        add_cell({24'sh0, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff,
                  24'sh800000, 24'sh0, 24'sh7fffff, 24'sh0});
        c = {9{24'sh01c71c}};
        add_cell(c);
        add_cell({24'sh071c72, 24'sh01c71c, 24'sh01c71c, 24'sh01c71c, 24'sh01c71c,
                  24'sh0071c7, 24'sh0071c7, 24'sh0071c7, 24'sh0071c7});
        random_cells(10);
        drain();

        // Sweep the relaxation rate through its extremes
        foreach (rates[r]) begin
            write_omega(rates[r]);
            random_cells(120);
            drain();
        end
        write_omega(22'd943718);

        // Long receiver hold-off while the sender keeps offering
        hold_cycles = 200;
        random_cells(150);
        drain();

        // A stretch with no idling on either side, then random idling again
        quiet_mode = 1'b1;
        random_cells(200);
        drain();
        quiet_mode = 1'b0;
        random_cells(130);
        drain();

        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
